// ===== rtl/sdaf_pkg.sv =====
// Package with shared constants and types for the signed decimal ASCII formatter.
`default_nettype none

package sdaf_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_DIGIT
  } sdaf_state_e;

endpackage

`default_nettype wire

// ===== rtl/sdaf_front.sv =====
// Front stage: takes a signed word and splits it into sign and magnitude.
`default_nettype none

module sdaf_front #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output logic                              push_valid_o,
  input  wire logic                         push_stall_i,
  output logic                              neg_o,
  output logic             [VALUE_BITS-1:0] mag_o
);

  logic                  valid_q, valid_d;
  logic                  neg_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic                  accept;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;

  assign in_stall_o = valid_q && push_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // The most negative value yields 2^(VALUE_BITS-1), which still fits unsigned.
  assign neg_in = value_i[VALUE_BITS-1];
  assign mag_in = neg_in ? (~value_i + VALUE_BITS'(1)) : value_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!push_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= neg_in;
      mag_q <= mag_in;
    end
  end

  assign push_valid_o = valid_q;
  assign neg_o        = neg_q;
  assign mag_o        = mag_q;

endmodule

`default_nettype wire

// ===== rtl/sdaf_queue.sv =====
// Two-entry queue between the front and back stages.
`default_nettype none

module sdaf_queue #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_stall_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_stall_o = (count_q == 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sdaf_back.sv =====
// Back stage: binary to BCD conversion four bits a cycle, then character output.
`default_nettype none

module sdaf_back
  import sdaf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  output logic                       q_pop_o,
  input  wire logic                  q_neg_i,
  input  wire logic [VALUE_BITS-1:0] q_mag_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [7:0]            ascii_char_o,
  output logic                       last_o
);

  localparam int NDIG  = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int NSTEP = (VALUE_BITS + 3) / 4;
  localparam int PAD   = 4 * NSTEP;
  localparam int PTR_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNT_W = $clog2(NSTEP + 1);

  sdaf_state_e      state_q, state_d;
  logic             neg_q;
  logic [PAD-1:0]   mag_q;
  logic [BCD_W-1:0] bcd_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PTR_W-1:0] ptr_q;
  logic             out_valid_q;
  logic [7:0]       ascii_q;
  logic             last_q;

  logic             slot_free;
  logic             emit;
  logic [7:0]       char_nxt;
  logic             last_nxt;
  logic [BCD_W-1:0] bcd_conv;
  logic [PTR_W-1:0] lead_ptr;
  logic [3:0]       cur_digit;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign cur_digit = bcd_q[4*ptr_q +: 4];

  // Four double-dabble steps per cycle.
  always_comb begin
    bcd_conv = bcd_q;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_conv[4*d +: 4] >= 4'd5) begin
          bcd_conv[4*d +: 4] = bcd_conv[4*d +: 4] + 4'd3;
        end
      end
      bcd_conv = {bcd_conv[BCD_W-2:0], mag_q[PAD-1-b]};
    end
  end

  always_comb begin
    lead_ptr = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[4*d +: 4] != 4'd0) begin
        lead_ptr = PTR_W'(d);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        state_d = neg_q ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free && (ptr_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    char_nxt = ASCII_ZERO + {4'd0, cur_digit};
    last_nxt = (ptr_q == '0);
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
      end
      ST_SIGN: begin
        emit     = slot_free;
        char_nxt = ASCII_MINUS;
        last_nxt = 1'b0;
      end
      ST_DIGIT: begin
        emit = slot_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        cnt_q <= CNT_W'(NSTEP);
      end else if (state_q == ST_CONV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      neg_q <= q_neg_i;
      mag_q <= PAD'(q_mag_i);
      bcd_q <= '0;
    end else if (state_q == ST_CONV) begin
      mag_q <= mag_q << 4;
      bcd_q <= bcd_conv;
    end
    if (state_q == ST_LEAD) begin
      ptr_q <= lead_ptr;
    end else if (emit && (state_q == ST_DIGIT) && (ptr_q != '0)) begin
      ptr_q <= ptr_q - PTR_W'(1);
    end
    if (emit) begin
      ascii_q <= char_nxt;
      last_q  <= last_nxt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = ascii_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/signed_decimal_ascii_formatter.sv =====
// Top level of the signed decimal ASCII formatter.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  value_i
//   out      output     out_valid_o / out_stall_i ascii_char_o, last_o
//
// Each number leaves the queue, goes through BCD conversion four bits at a
// time, has its leading digit found, then is sent as one character per cycle
// while the output is not stalled.
// Reset is asynchronous and clears the valid flags, queue pointers, counters and state.
// A stalled output holds its word, and the two-entry queue lets the front
// keep taking words while the back waits.
`default_nettype none

module signed_decimal_ascii_formatter
  import sdaf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic             [7:0]            ascii_char_o,
  output logic                              last_o
);

  logic                  f_valid;
  logic                  f_stall;
  logic                  f_neg;
  logic [VALUE_BITS-1:0] f_mag;
  logic                  q_valid;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_data;

  sdaf_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .push_valid_o(f_valid),
    .push_stall_i(f_stall),
    .neg_o       (f_neg),
    .mag_o       (f_mag)
  );

  sdaf_queue #(
    .WIDTH(VALUE_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_stall_o(f_stall),
    .push_data_i ({f_neg, f_mag}),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  sdaf_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_neg_i     (q_data[VALUE_BITS]),
    .q_mag_i     (q_data[VALUE_BITS-1:0]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the signed decimal ASCII formatter.
`timescale 1ns / 1ps

module tb_top;
  import sdaf_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } char_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [VB-1:0] value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           ascii_char_o;
  logic                 last_o;

  char_word_t  expected_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_pattern = '0;
  int unsigned stall_phase = 0;

  signed_decimal_ascii_formatter #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Pushes the decimal text of one value, sign first, most significant digit next.
  function automatic void predict_text(input logic signed [VB-1:0] v);
    longint     mag;
    logic [3:0] digits[0:19];
    int         n;
    char_word_t w;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (v < 0) begin
      w.ch = ASCII_MINUS;
      w.is_last = 1'b0;
      expected_chars.push_back(w);
    end
    for (int i = n - 1; i >= 0; i--) begin
      w.ch = ASCII_ZERO + 8'(digits[i]);
      w.is_last = (i == 0);
      expected_chars.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Both handshakes are sampled here, so prediction and checking share one process.
  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_text(value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected word, char", ascii_char_o, 8'd0);
        end else begin
          want = expected_chars.pop_front();
          if (ascii_char_o !== want.ch) begin
            report_mismatch("char", ascii_char_o, want.ch);
          end
          if (last_o !== want.is_last) begin
            report_mismatch("last", 8'(last_o), 8'(want.is_last));
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls on a rotating pattern that is redrawn now and then.
  always @(posedge clk_i) begin
    if (stall_phase % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = 16'($urandom);
        2: stall_pattern = 16'($urandom) | 16'($urandom);
        default: stall_pattern = 16'($urandom) & 16'($urandom);
      endcase
    end
    out_stall_i <= stall_pattern[stall_phase % 16];
    stall_phase++;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[signed_decimal_ascii_formatter] ERROR");
    $finish;
  end

  task automatic send_value(input logic signed [VB-1:0] v);
    int unsigned gap;
    in_valid_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        value_i <= VB'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_directed_values();
    logic signed [VB-1:0] vals[$];
    vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999999999, 1000000000,
             -1000000000, 2147483647, -2147483647, 32'sh8000_0000,
             32'sh5555_5555, 32'shAAAA_AAAA, 1234567890, -987654321, 7, -5};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Magnitudes spread over every digit count, with a random sign.
  task automatic test_random_lengths(input int count);
    int     ndig;
    longint lo;
    longint hi;
    longint mag;
    for (int k = 0; k < count; k++) begin
      ndig = $urandom_range(1, 10);
      lo = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      hi = (ndig == 10) ? 64'd2147483647 : 10 ** ndig - 1;
      mag = lo + longint'($urandom_range(0, int'(hi - lo)));
      send_value($urandom_range(0, 1) ? VB'(-mag) : VB'(mag));
    end
  endtask

  task automatic test_random_words(input int count);
    for (int k = 0; k < count; k++) begin
      send_value(VB'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_random_lengths(50);
    test_random_words(28);
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_chars.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("[signed_decimal_ascii_formatter] OK");
    end else begin
      $display("[signed_decimal_ascii_formatter] ERROR");
    end
    $finish;
  end

endmodule
